### src/barometric_sensor_compensation_unit_defines.svh
// assertion macros used by the port-level checker file
`ifndef BAROMETRIC_SENSOR_COMPENSATION_UNIT_DEFINES_SVH
`define BAROMETRIC_SENSOR_COMPENSATION_UNIT_DEFINES_SVH

// property checked at every edge, reset included
`define BSC_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("bsc check failed");

// property checked outside reset
`define BSC_ASSERT_RUN(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bsc check failed");

`endif

### src/bsc_pkg.sv
// types, constants and arithmetic helpers of the compensation unit
`timescale 1ns / 1ps
`default_nettype none
package bsc_pkg;

    localparam int unsigned PRE_STAGES  = 11;
    localparam int unsigned DIV_STEPS   = 64;
    localparam int unsigned DIV_LAT     = DIV_STEPS + 2;
    localparam int unsigned POST_STAGES = 5;
    localparam int unsigned LATENCY     = PRE_STAGES + DIV_LAT + POST_STAGES;

    localparam logic [63:0] PRESS_OFFSET = 64'd128000;
    localparam logic [63:0] RAW_FULL     = 64'd1048576;
    localparam logic [63:0] DIV_SCALE    = 64'd3125;
    localparam logic [31:0] ROUND_T      = 32'd128;
    localparam int unsigned SHIFT_P4     = 35;
    localparam int unsigned ONE_SHIFT    = 47;

    // register indexes
    localparam logic [2:0] REG_T1    = 3'd0;
    localparam logic [2:0] REG_T2_T3 = 3'd1;
    localparam logic [2:0] REG_P1    = 3'd2;
    localparam logic [2:0] REG_P2_P3 = 3'd3;
    localparam logic [2:0] REG_P4_P5 = 3'd4;
    localparam logic [2:0] REG_P6_P7 = 3'd5;
    localparam logic [2:0] REG_P8_P9 = 3'd6;

    // partial products of a 64 by 64 multiply, low half of the result only
    typedef struct packed {
        logic [63:0] lo;
        logic [31:0] mid;
    } t_pp;

    // sideband that travels with a word through the divider
    typedef struct packed {
        logic        valid;
        logic [31:0] temp;
        logic        fault;
    } t_div_side;

    function automatic t_pp pp_calc(input logic [63:0] a, input logic [63:0] b);
        t_pp         p;
        logic [31:0] m0;
        logic [31:0] m1;
        p.lo  = {32'd0, a[31:0]} * {32'd0, b[31:0]};
        m0    = a[63:32] * b[31:0];
        m1    = a[31:0] * b[63:32];
        p.mid = m0 + m1;
        return p;
    endfunction

    function automatic logic [63:0] pp_sum(input t_pp p);
        return p.lo + {p.mid, 32'd0};
    endfunction

    function automatic logic [63:0] sx16(input logic [15:0] h);
        return {{48{h[15]}}, h};
    endfunction

endpackage
`default_nettype wire

### src/barometric_sensor_compensation_unit.sv
// top level of the barometric compensation pipeline
//
// channel | signals                                         | direction
// --------+-------------------------------------------------+----------
// sample  | i_start, o_busy, i_raw_temperature, i_raw_pressure | in
// result  | o_valid, o_temperature_centi, o_pressure_q24_8,  | out
//         | o_coeff_fault                                   |
// config  | i_cfg_we, i_cfg_idx, i_cfg_wdata                | in
//
// one sample accepted every cycle; o_busy stays low
// the 64 one-bit steps of the pressure divider make up most of the pipeline,
// and multiplies split into 32-bit parts
// synchronous reset clears the valid bits and the coefficients
// the receiver cannot stall, so the pipeline advances every cycle
`timescale 1ns / 1ps
`default_nettype none
module barometric_sensor_compensation_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [19:0] i_raw_temperature,
    input  wire logic [19:0] i_raw_pressure,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_wdata,
    output logic             o_valid,
    output logic [31:0]      o_temperature_centi,
    output logic [31:0]      o_pressure_q24_8,
    output logic             o_coeff_fault
);
    import bsc_pkg::*;

    logic [15:0] r_t1;
    logic [31:0] r_t23;
    logic [15:0] r_p1;
    logic [31:0] r_p23, r_p45, r_p67, r_p89;

    // coefficient registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1 <= '0; r_t23 <= '0; r_p1 <= '0;
            r_p23 <= '0; r_p45 <= '0; r_p67 <= '0; r_p89 <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_T1:    r_t1  <= i_cfg_wdata[15:0];
                REG_T2_T3: r_t23 <= i_cfg_wdata;
                REG_P1:    r_p1  <= i_cfg_wdata[15:0];
                REG_P2_P3: r_p23 <= i_cfg_wdata;
                REG_P4_P5: r_p45 <= i_cfg_wdata;
                REG_P6_P7: r_p67 <= i_cfg_wdata;
                REG_P8_P9: r_p89 <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    logic [31:0] w_t2, w_t3;
    logic [63:0] w_p2, w_p3, w_p4, w_p5, w_p7, w_p8, w_p9, w_p6;
    assign w_t2 = {{16{r_t23[15]}}, r_t23[15:0]};
    assign w_t3 = {{16{r_t23[31]}}, r_t23[31:16]};
    assign w_p2 = sx16(r_p23[15:0]);
    assign w_p3 = sx16(r_p23[31:16]);
    assign w_p4 = sx16(r_p45[15:0]);
    assign w_p5 = sx16(r_p45[31:16]);
    assign w_p6 = sx16(r_p67[15:0]);
    assign w_p7 = sx16(r_p67[31:16]);
    assign w_p8 = sx16(r_p89[15:0]);
    assign w_p9 = sx16(r_p89[31:16]);

    // valid line of the front section
    logic [PRE_STAGES-2:0] r_pre_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_vld <= '0;
        end else begin
            r_pre_vld <= {r_pre_vld[PRE_STAGES-3:0], i_start};
        end
    end

    // temperature stages
    logic [31:0] w_a, w_d, w_fine;
    logic [31:0] r1_m1, r1_dd, r2_v1, r2_r, r3_fine;
    logic [63:0] r3_x1;
    logic [19:0] r1_rp, r2_rp, r3_rp, r4_rp, r5_rp, r6_rp, r7_rp, r8_rp;
    assign w_a    = {15'd0, i_raw_temperature[19:3]} - {15'd0, r_t1, 1'b0};
    assign w_d    = {16'd0, i_raw_temperature[19:4]} - {16'd0, r_t1};
    assign w_fine = r2_v1 + $unsigned($signed(r2_r) >>> 14);

    always_ff @(posedge i_clk) begin
        r1_m1   <= w_a * w_t2;
        r1_dd   <= w_d * w_d;
        r1_rp   <= i_raw_pressure;
        r2_v1   <= $unsigned($signed(r1_m1) >>> 11);
        r2_r    <= $unsigned($signed(r1_dd) >>> 12) * w_t3;
        r2_rp   <= r1_rp;
        r3_fine <= w_fine;
        r3_x1   <= {{32{w_fine[31]}}, w_fine} - PRESS_OFFSET;
        r3_rp   <= r2_rp;
    end

    // pressure coefficient stages
    logic [31:0] w_t5;
    logic [31:0] r4_temp, r5_temp, r6_temp, r7_temp, r8_temp, r9_temp, r10_temp;
    t_pp         r4_a, r4_b, r4_c, r6_a, r6_b, r9_pp, r10_pp;
    logic [63:0] r5_xx, r5_x1p5, r5_x1p2, r6_x1p5, r6_x1p2;
    logic [63:0] r7_xxp6, r7_xxp3, r7_x1p5, r7_x1p2;
    logic [63:0] r8_x2, r8_x1b, r9_n0, r10_s;
    assign w_t5 = {r3_fine[29:0], 2'b00} + r3_fine + ROUND_T;

    always_ff @(posedge i_clk) begin
        r4_a    <= pp_calc(r3_x1, r3_x1);
        r4_b    <= pp_calc(r3_x1, w_p5);
        r4_c    <= pp_calc(r3_x1, w_p2);
        r4_temp <= $unsigned($signed(w_t5) >>> 8);
        r4_rp   <= r3_rp;
        r5_xx   <= pp_sum(r4_a);
        r5_x1p5 <= pp_sum(r4_b);
        r5_x1p2 <= pp_sum(r4_c);
        r5_temp <= r4_temp;
        r5_rp   <= r4_rp;
        r6_a    <= pp_calc(r5_xx, w_p6);
        r6_b    <= pp_calc(r5_xx, w_p3);
        r6_x1p5 <= r5_x1p5;
        r6_x1p2 <= r5_x1p2;
        r6_temp <= r5_temp;
        r6_rp   <= r5_rp;
        r7_xxp6 <= pp_sum(r6_a);
        r7_xxp3 <= pp_sum(r6_b);
        r7_x1p5 <= r6_x1p5;
        r7_x1p2 <= r6_x1p2;
        r7_temp <= r6_temp;
        r7_rp   <= r6_rp;
        r8_x2   <= r7_xxp6 + {r7_x1p5[46:0], 17'd0} + (w_p4 << SHIFT_P4);
        r8_x1b  <= $unsigned($signed(r7_xxp3) >>> 8) + {r7_x1p2[51:0], 12'd0};
        r8_temp <= r7_temp;
        r8_rp   <= r7_rp;
        r9_pp   <= pp_calc(r8_x1b + (64'd1 << ONE_SHIFT), {48'd0, r_p1});
        r9_n0   <= ((RAW_FULL - {44'd0, r8_rp}) << 31) - r8_x2;
        r9_temp <= r8_temp;
        r10_s   <= pp_sum(r9_pp);
        r10_pp  <= pp_calc(r9_n0, DIV_SCALE);
        r10_temp <= r9_temp;
    end

    // divider operands
    logic [63:0] w_den;
    logic [63:0] r11_num, r11_den;
    t_div_side   r11_side;
    assign w_den = $unsigned($signed(r10_s) >>> 33);

    always_ff @(posedge i_clk) begin
        r11_num        <= pp_sum(r10_pp);
        r11_den        <= w_den;
        r11_side.temp  <= r10_temp;
        r11_side.fault <= (w_den == 64'd0);
        r11_side.valid <= r_pre_vld[PRE_STAGES-2];
    end

    logic [63:0] w_quo;
    t_div_side   w_dside;

    bsc_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_num  (r11_num),
        .i_den  (r11_den),
        .i_side (r11_side),
        .o_quo  (w_quo),
        .o_side (w_dside)
    );

    // back section valid line
    logic [POST_STAGES-2:0] r_post_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_post_vld <= '0;
            o_valid    <= 1'b0;
        end else begin
            r_post_vld <= {r_post_vld[POST_STAGES-3:0], w_dside.valid};
            o_valid    <= r_post_vld[POST_STAGES-2];
        end
    end

    // pressure refinement stages
    logic [63:0] w_q, w_pf;
    t_pp         ra_qq, ra_p8, rc_pp;
    logic [63:0] ra_p, rb_p, rc_p, rd_p, rb_qq, rb_y2, rc_y2, rd_y2, rd_y1;
    logic [31:0] ra_temp, rb_temp, rc_temp, rd_temp;
    logic        ra_fault, rb_fault, rc_fault, rd_fault;
    assign w_q  = $unsigned($signed(w_quo) >>> 13);
    assign w_pf = $unsigned($signed(rd_p + rd_y1 + rd_y2) >>> 8) + {w_p7[59:0], 4'd0};

    always_ff @(posedge i_clk) begin
        ra_qq    <= pp_calc(w_q, w_q);
        ra_p8    <= pp_calc(w_quo, w_p8);
        ra_p     <= w_quo;
        ra_temp  <= w_dside.temp;
        ra_fault <= w_dside.fault;
        rb_qq    <= pp_sum(ra_qq);
        rb_y2    <= $unsigned($signed(pp_sum(ra_p8)) >>> 19);
        rb_p     <= ra_p;
        rb_temp  <= ra_temp;
        rb_fault <= ra_fault;
        rc_pp    <= pp_calc(rb_qq, w_p9);
        rc_y2    <= rb_y2;
        rc_p     <= rb_p;
        rc_temp  <= rb_temp;
        rc_fault <= rb_fault;
        rd_y1    <= $unsigned($signed(pp_sum(rc_pp)) >>> 25);
        rd_y2    <= rc_y2;
        rd_p     <= rc_p;
        rd_temp  <= rc_temp;
        rd_fault <= rc_fault;
        o_temperature_centi <= rd_temp;
        o_pressure_q24_8    <= rd_fault ? 32'd0 : w_pf[31:0];
        o_coeff_fault       <= rd_fault;
    end

    assign o_busy = 1'b0;
endmodule
`default_nettype wire

### src/bsc_div.sv
// pipelined signed 64-bit divider, truncating toward zero, one quotient bit a stage
`timescale 1ns / 1ps
`default_nettype none
module bsc_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [63:0]        i_num,
    input  wire logic [63:0]        i_den,
    input  wire bsc_pkg::t_div_side i_side,
    output logic [63:0]             o_quo,
    output bsc_pkg::t_div_side      o_side
);
    import bsc_pkg::*;

    logic [63:0] r_rem [0:DIV_STEPS];
    logic [63:0] r_nq  [0:DIV_STEPS];
    logic [63:0] r_den [0:DIV_STEPS];
    logic        r_neg [0:DIV_STEPS];
    t_div_side   r_side [0:DIV_STEPS];
    logic [63:0] r_quo;
    t_div_side   r_oside;

    // magnitudes and result sign
    always_ff @(posedge i_clk) begin
        r_rem[0] <= 64'd0;
        r_nq[0]  <= i_num[63] ? (64'd0 - i_num) : i_num;
        r_den[0] <= i_den[63] ? (64'd0 - i_den) : i_den;
        r_neg[0] <= i_num[63] ^ i_den[63];
        r_side[0].temp  <= i_side.temp;
        r_side[0].fault <= i_side.fault;
        if (!i_rst_n) begin
            r_side[0].valid <= 1'b0;
        end else begin
            r_side[0].valid <= i_side.valid;
        end
    end

    // restoring steps
    for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
        logic [64:0] w_cat;
        logic [64:0] w_diff;
        assign w_cat  = {r_rem[k-1], r_nq[k-1][63]};
        assign w_diff = w_cat - {1'b0, r_den[k-1]};
        always_ff @(posedge i_clk) begin
            r_rem[k] <= w_diff[64] ? w_cat[63:0] : w_diff[63:0];
            r_nq[k]  <= {r_nq[k-1][62:0], ~w_diff[64]};
            r_den[k] <= r_den[k-1];
            r_neg[k] <= r_neg[k-1];
            r_side[k].temp  <= r_side[k-1].temp;
            r_side[k].fault <= r_side[k-1].fault;
            if (!i_rst_n) begin
                r_side[k].valid <= 1'b0;
            end else begin
                r_side[k].valid <= r_side[k-1].valid;
            end
        end
    end

    // sign fix
    always_ff @(posedge i_clk) begin
        r_quo <= r_neg[DIV_STEPS] ? (64'd0 - r_nq[DIV_STEPS]) : r_nq[DIV_STEPS];
        r_oside.temp  <= r_side[DIV_STEPS].temp;
        r_oside.fault <= r_side[DIV_STEPS].fault;
        if (!i_rst_n) begin
            r_oside.valid <= 1'b0;
        end else begin
            r_oside.valid <= r_side[DIV_STEPS].valid;
        end
    end

    assign o_quo  = r_quo;
    assign o_side = r_oside;
endmodule
`default_nettype wire

### src/bsc_checker.sv
// port-level checks of the compensation unit and their bind
`timescale 1ns / 1ps
`default_nettype none
`include "barometric_sensor_compensation_unit_defines.svh"
module bsc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_start,
    input wire logic        o_busy,
    input wire logic        o_valid,
    input wire logic [31:0] o_pressure_q24_8,
    input wire logic        o_coeff_fault
);
    import bsc_pkg::*;

    // reset empties the result strobe
    `BSC_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !o_valid)
    // a faulted result carries zero pressure
    `BSC_ASSERT_RUN(a_fault_zero, i_clk, i_rst_n,
        (o_valid && o_coeff_fault) |-> (o_pressure_q24_8 == 32'd0))
    // every result stems from a word taken a fixed latency earlier
    `BSC_ASSERT_RUN(a_latency, i_clk, i_rst_n,
        o_valid |-> $past(i_start && !o_busy, LATENCY))
    // the unit never holds off a sample
    `BSC_ASSERT_RUN(a_never_busy, i_clk, i_rst_n, !o_busy)
endmodule

bind barometric_sensor_compensation_unit bsc_checker u_bsc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_start         (i_start),
    .o_busy          (o_busy),
    .o_valid         (o_valid),
    .o_pressure_q24_8(o_pressure_q24_8),
    .o_coeff_fault   (o_coeff_fault)
);
`default_nettype wire

### test/barometric_sensor_compensation_unit_checker.sv
// result checker for the barometric compensation unit: predicts and compares each word
`timescale 1ns / 1ps
`default_nettype none
module barometric_sensor_compensation_unit_checker
    import bsc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic        i_busy,
    input  wire logic [19:0] i_raw_temperature,
    input  wire logic [19:0] i_raw_pressure,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_wdata,
    input  wire logic        i_valid,
    input  wire logic [31:0] i_temperature_centi,
    input  wire logic [31:0] i_pressure_q24_8,
    input  wire logic        i_coeff_fault,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_seen,
    output int               o_faults_seen
);

    typedef struct packed {
        logic [31:0] temp;
        logic [31:0] press;
        logic        fault;
    } t_reading;

    logic [15:0] coef_t1;
    logic [31:0] coef_t2_t3;
    logic [15:0] coef_p1;
    logic [31:0] coef_p2_p3;
    logic [31:0] coef_p4_p5;
    logic [31:0] coef_p6_p7;
    logic [31:0] coef_p8_p9;

    t_reading expected_readings[$];

    assign o_pending = expected_readings.size();

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
        o_fail_count++;
    endtask

    // signed divide truncating toward zero, wrapping on overflow
    function automatic logic [63:0] div_trunc(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] mn;
        logic [63:0] md;
        logic [63:0] q;
        mn = n[63] ? -n : n;
        md = d[63] ? -d : d;
        q  = mn / md;
        return (n[63] != d[63]) ? -q : q;
    endfunction

    // compensation formulas for one raw sample
    function automatic t_reading compensate(input logic [19:0] rt, input logic [19:0] rp);
        t_reading    r;
        logic signed [31:0] t2, t3, a, v1, dd, v2, fine;
        logic signed [63:0] p2, p3, p4, p5, p6, p7, p8, p9, x1, x2, p, q, y1, y2;
        logic [63:0] p1;
        t2   = signed'({{16{coef_t2_t3[15]}}, coef_t2_t3[15:0]});
        t3   = signed'({{16{coef_t2_t3[31]}}, coef_t2_t3[31:16]});
        a    = (32'(rt) >> 3) - (32'(coef_t1) << 1);
        v1   = (a * t2) >>> 11;
        dd   = (32'(rt) >> 4) - 32'(coef_t1);
        v2   = (((dd * dd) >>> 12) * t3) >>> 14;
        fine = v1 + v2;
        r.temp = (fine * 5 + signed'(ROUND_T)) >>> 8;
        p1 = 64'(coef_p1);
        p2 = signed'({{48{coef_p2_p3[15]}}, coef_p2_p3[15:0]});
        p3 = signed'({{48{coef_p2_p3[31]}}, coef_p2_p3[31:16]});
        p4 = signed'({{48{coef_p4_p5[15]}}, coef_p4_p5[15:0]});
        p5 = signed'({{48{coef_p4_p5[31]}}, coef_p4_p5[31:16]});
        p6 = signed'({{48{coef_p6_p7[15]}}, coef_p6_p7[15:0]});
        p7 = signed'({{48{coef_p6_p7[31]}}, coef_p6_p7[31:16]});
        p8 = signed'({{48{coef_p8_p9[15]}}, coef_p8_p9[15:0]});
        p9 = signed'({{48{coef_p8_p9[31]}}, coef_p8_p9[31:16]});
        x1 = 64'(fine) - signed'(PRESS_OFFSET);
        x2 = x1 * x1 * p6;
        x2 = x2 + ((x1 * p5) << 17);
        x2 = x2 + (p4 << SHIFT_P4);
        x1 = ((x1 * x1 * p3) >>> 8) + ((x1 * p2) << 12);
        x1 = ((64'sd1 <<< ONE_SHIFT) + x1) * signed'(p1);
        x1 = x1 >>> 33;
        r.press = '0;
        r.fault = 1'b0;
        if (x1 == 0) begin
            r.fault = 1'b1;
        end else begin
            p  = signed'(RAW_FULL) - 64'(rp);
            p  = signed'(div_trunc(((p << 31) - x2) * signed'(DIV_SCALE), x1));
            q  = p >>> 13;
            y1 = (p9 * q * q) >>> 25;
            y2 = (p8 * p) >>> 19;
            p  = ((p + y1 + y2) >>> 8) + (p7 << 4);
            r.press = p[31:0];
        end
        return r;
    endfunction

    // coefficient shadow, prediction on accept, compare on strobe
    always @(posedge i_clk) begin
        t_reading want;
        if (!i_rst_n) begin
            coef_t1 <= '0; coef_t2_t3 <= '0; coef_p1 <= '0; coef_p2_p3 <= '0;
            coef_p4_p5 <= '0; coef_p6_p7 <= '0; coef_p8_p9 <= '0;
        end else begin
            if (i_valid) begin
                o_seen++;
                if (i_coeff_fault) o_faults_seen++;
                if (expected_readings.size() == 0) begin
                    $display("%0t unexpected word", $realtime);
                    o_fail_count++;
                end else begin
                    want = expected_readings.pop_front();
                    if (i_temperature_centi !== want.temp)
                        report_mismatch("temperature", i_temperature_centi, want.temp);
                    if (i_pressure_q24_8 !== want.press)
                        report_mismatch("pressure", i_pressure_q24_8, want.press);
                    if (i_coeff_fault !== want.fault)
                        report_mismatch("fault", 32'(i_coeff_fault), 32'(want.fault));
                end
            end
            if (i_start && !i_busy)
                expected_readings.push_back(compensate(i_raw_temperature, i_raw_pressure));
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_T1:    coef_t1    <= i_cfg_wdata[15:0];
                    REG_T2_T3: coef_t2_t3 <= i_cfg_wdata;
                    REG_P1:    coef_p1    <= i_cfg_wdata[15:0];
                    REG_P2_P3: coef_p2_p3 <= i_cfg_wdata;
                    REG_P4_P5: coef_p4_p5 <= i_cfg_wdata;
                    REG_P6_P7: coef_p6_p7 <= i_cfg_wdata;
                    REG_P8_P9: coef_p8_p9 <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    initial begin
        o_fail_count  = 0;
        o_seen        = 0;
        o_faults_seen = 0;
    end

endmodule
`default_nettype wire

### test/barometric_sensor_compensation_unit_tb.sv
// testbench top: sample stimulus, coefficient phases and the verdict
`timescale 1ns / 1ps
`default_nettype none
module barometric_sensor_compensation_unit_tb;
    import bsc_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [19:0] raw_t = '0;
    logic [19:0] raw_p = '0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_idx = '0;
    logic [31:0] cfg_wdata = '0;
    logic        res_valid;
    logic [31:0] res_temp;
    logic [31:0] res_press;
    logic        res_fault;
    int          fail_count, pending, seen, faults_seen;
    int          sent = 0;
    int          idle_pct = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    barometric_sensor_compensation_unit dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .o_busy(busy),
        .i_raw_temperature(raw_t), .i_raw_pressure(raw_p),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_wdata(cfg_wdata),
        .o_valid(res_valid), .o_temperature_centi(res_temp),
        .o_pressure_q24_8(res_press), .o_coeff_fault(res_fault)
    );

    barometric_sensor_compensation_unit_checker checker_i (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .i_busy(busy),
        .i_raw_temperature(raw_t), .i_raw_pressure(raw_p),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_wdata(cfg_wdata),
        .i_valid(res_valid), .i_temperature_centi(res_temp),
        .i_pressure_q24_8(res_press), .i_coeff_fault(res_fault),
        .o_fail_count(fail_count), .o_pending(pending), .o_seen(seen),
        .o_faults_seen(faults_seen)
    );

    // one coefficient write
    task automatic write_coef(input logic [2:0] idx, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // wait for the pipeline to drain before touching coefficients
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // present one sample, idling first as the phase asks
    task automatic send_sample(input logic [19:0] t, input logic [19:0] p);
        while ($urandom_range(99, 0) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        raw_t <= t;
        raw_p <= p;
        @(posedge clk);
        while (busy) @(posedge clk);
        sent++;
    endtask

    // random 16-bit coefficient, extremes now and then
    function automatic logic [15:0] pick16();
        case ($urandom_range(7, 0))
            0: return 16'h0000;
            1: return 16'hffff;
            2: return 16'h7fff;
            3: return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic load_coefs(input bit typical);
        if (typical) begin
            // realistic factory set with small jitter
            write_coef(REG_T1, 32'd27504 + $urandom_range(400, 0));
            write_coef(REG_T2_T3, {16'(-16'sd1000), 16'd26435 + 16'($urandom_range(300, 0))});
            write_coef(REG_P1, 32'd36477 + $urandom_range(500, 0));
            write_coef(REG_P2_P3, {16'd3024, 16'(-16'sd10685)});
            write_coef(REG_P4_P5, {16'(-16'sd140), 16'd2855});
            write_coef(REG_P6_P7, {16'd15500, 16'(-16'sd7)});
            write_coef(REG_P8_P9, {16'd6000, 16'(-16'sd14600)});
        end else begin
            write_coef(REG_T1, {16'($urandom), pick16()});
            write_coef(REG_T2_T3, {pick16(), pick16()});
            write_coef(REG_P1, {16'($urandom), pick16()});
            write_coef(REG_P2_P3, {pick16(), pick16()});
            write_coef(REG_P4_P5, {pick16(), pick16()});
            write_coef(REG_P6_P7, {pick16(), pick16()});
            write_coef(REG_P8_P9, {pick16(), pick16()});
        end
        // index beyond the register list is ignored
        write_coef(3'd7, $urandom);
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset coefficients give a zero divisor
        send_sample(20'h00000, 20'h00000);
        send_sample(20'hfffff, 20'hfffff);
        drain();

        // directed extremes under a typical set, then under a set of extreme coefficients
        load_coefs(1'b1);
        send_sample(20'h00000, 20'h00000);
        send_sample(20'hfffff, 20'hfffff);
        send_sample(20'h80000, 20'h55555);
        send_sample(20'h7ffff, 20'haaaaa);
        send_sample(20'd519888, 20'd415148);
        drain();
        write_coef(REG_T1, 32'h0000ffff);
        write_coef(REG_T2_T3, 32'h7fff7fff);
        write_coef(REG_P1, 32'h0000ffff);
        write_coef(REG_P2_P3, 32'h80008000);
        write_coef(REG_P4_P5, 32'h7fff8000);
        write_coef(REG_P6_P7, 32'hffffffff);
        write_coef(REG_P8_P9, 32'h80007fff);
        send_sample(20'h00000, 20'hfffff);
        send_sample(20'hfffff, 20'h00000);
        send_sample(20'h12345, 20'h6789a);
        drain();
        // p1 zero: divisor zero with nonzero other coefficients
        write_coef(REG_P1, 32'd0);
        send_sample(20'h54321, 20'h0abcd);
        drain();

        // random phases over idling modes and coefficient sets
        for (int ph = 0; ph < 12; ph++) begin
            case (ph % 4)
                0: idle_pct = 0;
                1: idle_pct = 83;
                2: idle_pct = 18;
                default: idle_pct = $urandom_range(40, 0);
            endcase
            load_coefs(ph % 3 != 2);
            for (int n = 0; n < 87; n++) begin
                if ($urandom_range(3, 0) != 0)
                    send_sample(20'd400000 + 20'($urandom_range(250000, 0)),
                                20'd250000 + 20'($urandom_range(300000, 0)));
                else
                    send_sample(20'($urandom), 20'($urandom));
            end
            drain();
        end

        $display("sent %0d samples, checked %0d words, %0d with the divisor fault",
                 sent, seen, faults_seen);
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #20ms;
        $display("timeout");
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
`default_nettype wire

### filelist.f
+incdir+src
src/bsc_pkg.sv
src/bsc_div.sv
src/barometric_sensor_compensation_unit.sv
src/bsc_checker.sv
test/barometric_sensor_compensation_unit_checker.sv
test/barometric_sensor_compensation_unit_tb.sv
